>>> rtl/medf_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
package medf_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int IMAGE_WIDTH_RESET  = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;

   localparam int PIX_W       = 8;
   localparam int IMG_W_W     = 12;
   localparam int IMG_H_W     = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int WIN_TAPS    = 9;
   localparam int FIFO_DEPTH  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WIN_TAPS-1:0] pix9_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

>>> rtl/medf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module medf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read-during-write to the same address returns the old word
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/medf_median9.sv
// Three-stage pipelined median of nine: row sorts, then max/med/min, then final med3.
module medf_median9 (
   input  logic                clock,
   input  logic                reset,
   input  medf_pkg::tag_type   in_tag,
   input  medf_pkg::pix9_type  in_pix,
   output medf_pkg::tag_type   out_tag,
   output medf_pkg::pix_type   out_median
);

   medf_pkg::tag_type tag_a_ff, tag_b_ff, tag_c_ff;
   medf_pkg::pix_type lo_ff [3], md_ff [3], hi_ff [3];
   medf_pkg::pix_type lo_in [3], md_in [3], hi_in [3];
   medf_pkg::pix_type max_lo_ff, med_md_ff, min_hi_ff;
   medf_pkg::pix_type max_lo_in, med_md_in, min_hi_in;
   medf_pkg::pix_type median_ff, median_in;

   // sort each window row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         lo_in[r] = medf_pkg::min2(medf_pkg::min2(in_pix[r*3], in_pix[r*3+1]), in_pix[r*3+2]);
         hi_in[r] = medf_pkg::max2(medf_pkg::max2(in_pix[r*3], in_pix[r*3+1]), in_pix[r*3+2]);
         md_in[r] = medf_pkg::med3(in_pix[r*3], in_pix[r*3+1], in_pix[r*3+2]);
      end
   end

   always_comb begin
      max_lo_in = medf_pkg::max2(medf_pkg::max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
      med_md_in = medf_pkg::med3(md_ff[0], md_ff[1], md_ff[2]);
      min_hi_in = medf_pkg::min2(medf_pkg::min2(hi_ff[0], hi_ff[1]), hi_ff[2]);
      median_in = medf_pkg::med3(max_lo_ff, med_md_ff, min_hi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else begin
         tag_a_ff <= in_tag;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         lo_ff[r] <= lo_in[r];
         md_ff[r] <= md_in[r];
         hi_ff[r] <= hi_in[r];
      end
      max_lo_ff <= max_lo_in;
      med_md_ff <= med_md_in;
      min_hi_ff <= min_hi_in;
      median_ff <= median_in;
   end

   assign out_tag    = tag_c_ff;
   assign out_median = median_ff;

endmodule

>>> rtl/median_filter_3x3_unit.sv
// Top level of the streaming zero-padded 3x3 median filter.
// Throughput: one request per cycle while FIFO credits remain; the line store RAM takes one read
//   and one write per cycle, with a forwarding register covering back-to-back hits on one column.
// Result path: a result follows the request that completes its neighborhood (one line plus one
//   pixel later in the stream) through the line store read, the row sorts, two more median
//   stages, then the FIFO write.
// An 8-entry result FIFO with credit count lets requests flow while a result waits.
// Reset: counters, window and FIFO clear at once; line store contents stay undefined and are
//   masked by the border logic, so no clearing pass is run.
module median_filter_3x3_unit #(
   parameter int MAX_WIDTH = medf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [medf_pkg::PIX_W-1:0]         req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [medf_pkg::PIX_W-1:0]         rsp_median,
   output logic                               rsp_frame_last,
   input  logic                               csr_we,
   input  logic [medf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [medf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int HW  = medf_pkg::IMG_H_W;
   localparam int RW  = HW + 1;
   localparam int FPW = $clog2(medf_pkg::FIFO_DEPTH);
   localparam int FCW = $clog2(medf_pkg::FIFO_DEPTH + 1);
   localparam int LW  = 2 * medf_pkg::PIX_W;
   localparam logic [AW-1:0] W_M1_RESET = AW'((medf_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                              MAX_WIDTH - 1 : medf_pkg::IMAGE_WIDTH_RESET - 1);
   localparam logic [HW-1:0] H_M1_RESET = HW'(medf_pkg::IMAGE_HEIGHT_RESET - 1);

   typedef struct packed {
      logic              emit;
      logic              last;
      logic              top_ok;
      logic              bot_ok;
      logic              left_ok;
      logic              right_ok;
      logic [AW-1:0]     col;
      medf_pkg::pix_type sample;
   } stage1_type;

   typedef struct packed {
      logic              last;
      medf_pkg::pix_type median;
   } fifo_entry_type;

   // ---------------- configuration ----------------
   logic [AW-1:0] w_m1_ff, w_m1_in;
   logic [HW-1:0] h_m1_ff, h_m1_in;
   logic          restart;
   logic [medf_pkg::IMG_W_W-1:0] w_val;
   logic [HW-1:0]                h_val;

   assign w_val = csr_wdata[medf_pkg::IMG_W_W-1:0];
   assign h_val = csr_wdata[HW-1:0];

   always_comb begin
      w_m1_in = w_m1_ff;
      h_m1_in = h_m1_ff;
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            medf_pkg::CSR_IMAGE_WIDTH: begin
               restart = 1'b1;
               if (w_val == '0) begin
                  w_m1_in = '0;
               end else if (32'(w_val) > MAX_WIDTH) begin
                  w_m1_in = AW'(MAX_WIDTH - 1);
               end else begin
                  w_m1_in = AW'(w_val - 1'b1);
               end
            end
            medf_pkg::CSR_IMAGE_HEIGHT: begin
               restart = 1'b1;
               h_m1_in = (h_val == '0) ? '0 : h_val - 1'b1;
            end
            default: ;
         endcase
      end
   end

   // ---------------- raster position and border flags ----------------
   logic [AW-1:0] col_ff, col_in, ccol;
   logic [RW-1:0] row_ff, row_in, crow, h_m1_x;
   logic          req_accept, col_zero, col_wrap;
   logic          st0_emit, st0_last;
   stage1_type    st0;

   assign req_accept = req_valid && req_ready;
   assign h_m1_x     = RW'(h_m1_ff);
   assign col_zero   = (col_ff == '0);
   assign col_wrap   = (col_ff == w_m1_ff);

   always_comb begin
      // the first column of a line closes the neighborhood centered on the end of the line two lines back
      crow     = col_zero ? row_ff - RW'(2) : row_ff - RW'(1);
      ccol     = col_zero ? w_m1_ff : col_ff - AW'(1);
      st0_emit = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && !col_zero);
      st0_last = st0_emit && (crow >= h_m1_x) && (ccol == w_m1_ff);

      st0.emit     = st0_emit;
      st0.last     = st0_last;
      st0.top_ok   = (crow != '0);
      st0.bot_ok   = (crow < h_m1_x);
      st0.left_ok  = (ccol != '0);
      st0.right_ok = (ccol != w_m1_ff);
      st0.col      = col_ff;
      // flush slots and slots past the last line feed zero
      st0.sample   = (!req_func && (row_ff <= h_m1_x)) ? req_pixel : '0;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (st0_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // ---------------- line store ----------------
   logic          s1_valid_ff;
   stage1_type    s1_ff;
   logic          fwd_hit_ff, fwd_hit_in;
   logic [LW-1:0] fwd_data_ff, fwd_data_in;
   logic [LW-1:0] ram_rd_data, line_word;
   medf_pkg::pix_type top_pix, mid_pix;

   medf_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.col),
      .wr_data ({mid_pix, s1_ff.sample}),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // a read issued while the previous request writes the same column sees stale data
   assign fwd_hit_in  = s1_valid_ff && (col_ff == s1_ff.col);
   assign fwd_data_in = {mid_pix, s1_ff.sample};
   assign line_word   = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign top_pix     = line_word[LW-1:medf_pkg::PIX_W];
   assign mid_pix     = line_word[medf_pkg::PIX_W-1:0];

   // ---------------- window ----------------
   medf_pkg::pix9_type win_ff, win_in, shifted, nb_pix;
   medf_pkg::tag_type  nb_tag, med_tag;
   medf_pkg::pix_type  med_pix;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         shifted[r*3]   = win_ff[r*3+1];
         shifted[r*3+1] = win_ff[r*3+2];
      end
      shifted[2] = top_pix;
      shifted[5] = mid_pix;
      shifted[8] = s1_ff.sample;

      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && !s1_ff.top_ok) || (r == 2 && !s1_ff.bot_ok) ||
                (c == 0 && !s1_ff.left_ok) || (c == 2 && !s1_ff.right_ok)) begin
               nb_pix[r*3+c] = '0;
            end else begin
               nb_pix[r*3+c] = shifted[r*3+c];
            end
         end
      end

      win_in = win_ff;
      if (restart) begin
         win_in = '0;
      end else if (s1_valid_ff) begin
         win_in = s1_ff.last ? '0 : shifted;
      end
   end

   assign nb_tag.valid = s1_valid_ff && s1_ff.emit;
   assign nb_tag.last  = s1_ff.last;

   medf_median9 u_median (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (nb_tag),
      .in_pix     (nb_pix),
      .out_tag    (med_tag),
      .out_median (med_pix)
   );

   // ---------------- result FIFO and credits ----------------
   fifo_entry_type   fifo_mem_ff [medf_pkg::FIFO_DEPTH];
   logic [FPW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FCW-1:0]   fifo_count_ff, fifo_count_in, occupancy_ff, occupancy_in;
   logic             push, pop, credit_take;
   fifo_entry_type   push_entry;

   assign push        = med_tag.valid;
   assign pop         = rsp_valid && rsp_ready;
   assign credit_take = req_accept && st0_emit;
   assign push_entry  = '{last: med_tag.last, median: med_pix};

   assign rsp_valid      = (fifo_count_ff != '0);
   assign rsp_median     = fifo_mem_ff[rd_ptr_ff].median;
   assign rsp_frame_last = fifo_mem_ff[rd_ptr_ff].last;
   // every request that will yield a result holds a FIFO slot from acceptance on
   assign req_ready      = (occupancy_ff < FCW'(medf_pkg::FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FPW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FPW'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fifo_count_in = fifo_count_ff + FCW'(1);
         2'b01:   fifo_count_in = fifo_count_ff - FCW'(1);
         default: fifo_count_in = fifo_count_ff;
      endcase
      case ({credit_take, pop})
         2'b10:   occupancy_in = occupancy_ff + FCW'(1);
         2'b01:   occupancy_in = occupancy_ff - FCW'(1);
         default: occupancy_in = occupancy_ff;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff       <= W_M1_RESET;
         h_m1_ff       <= H_M1_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         win_ff        <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
         occupancy_ff  <= '0;
      end else begin
         w_m1_ff       <= w_m1_in;
         h_m1_ff       <= h_m1_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= req_accept;
         fwd_hit_ff    <= fwd_hit_in;
         win_ff        <= win_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
         occupancy_ff  <= occupancy_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= st0;
      fwd_data_ff <= fwd_data_in;
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // ---------------- assertions ----------------
   assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= FCW'(medf_pkg::FIFO_DEPTH))
      else $error("credit count exceeds FIFO depth");

   assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_count_ff < FCW'(medf_pkg::FIFO_DEPTH)))
      else $error("result pushed into full FIFO");

   assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= occupancy_ff)
      else $error("FIFO holds more results than credits taken");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && st0_last) |=> ((col_ff == '0) && (row_ff == '0)))
      else $error("frame end did not restart raster position");

endmodule
